// File: sv/sp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp_pkg
// opcodes, i/o register indexes and shared types of the risc core
// ----------------------------------------------------------------------------
package sp_pkg;

  typedef enum logic [7:0] {
    OP_ADD  = 8'd0,
    OP_SUB  = 8'd1,
    OP_AND  = 8'd2,
    OP_OR   = 8'd3,
    OP_SLL  = 8'd4,
    OP_SRA  = 8'd5,
    OP_SRL  = 8'd6,
    OP_BEQ  = 8'd7,
    OP_BNE  = 8'd8,
    OP_BLT  = 8'd9,
    OP_BGT  = 8'd10,
    OP_BLE  = 8'd11,
    OP_BGE  = 8'd12,
    OP_JAL  = 8'd13,
    OP_LW   = 8'd14,
    OP_SW   = 8'd15,
    OP_RETI = 8'd16,
    OP_IN   = 8'd17,
    OP_OUT  = 8'd18,
    OP_HALT = 8'd19
  } opcode_t;

  typedef enum logic [1:0] {
    IO_NONE  = 2'd0,
    IO_READ  = 2'd1,
    IO_WRITE = 2'd2
  } io_access_t;

  localparam int IRQ0_ENABLE  = 0;
  localparam int IRQ1_ENABLE  = 1;
  localparam int IRQ2_ENABLE  = 2;
  localparam int IRQ0_STATUS  = 3;
  localparam int IRQ1_STATUS  = 4;
  localparam int IRQ2_STATUS  = 5;
  localparam int IRQ_HANDLER  = 6;
  localparam int IRQ_RETURN   = 7;
  localparam int CLKS         = 8;
  localparam int LEDS         = 9;
  localparam int DISPLAY      = 10;
  localparam int TIMER_ENABLE = 11;
  localparam int TIMER_CUR    = 12;
  localparam int TIMER_MAX    = 13;

  localparam int PC_W = 12;

  typedef struct packed {
    logic [31:0] value;
    logic        taken;
  } alu_res_t;

endpackage
`default_nettype wire

// File: sv/simple_risc_core_with_interrupts.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// simple_risc_core_with_interrupts
// one instruction per beat core with register file, data memory, i/o and irqs
// ----------------------------------------------------------------------------
// registers: input register, result register, from input beat to result beat;
// throughput: one beat per cycle while m_tready takes the results, a load
// command gives no result. reset: register file, i/o registers, pc and flags
// cleared; then the data memory is swept to zero, one word a cycle, during
// which s_tready stays low. a lw result comes from the registered memory read
// port in the following cycle and is forwarded to the next instruction.
module simple_risc_core_with_interrupts #(
  parameter int MEM_WORDS    = 4096,
  parameter int IO_REG_COUNT = 18
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // instruction[31:0], irq2_event[32], load_address[44:33], load_data[76:45]
  input  wire logic [79:0]  s_tdata,
  // command[0]
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // next_pc[11:0], halted[12], cycle_number[44:13], io_access[46:45],
  // io_index[51:47], io_data[83:52], leds_changed[84], leds_value[116:85],
  // display_changed[117], display_value[149:118]
  output logic [151:0]      m_tdata
);
  import sp_pkg::*;

  localparam int AW   = $clog2(MEM_WORDS);
  localparam int IOW  = $clog2(IO_REG_COUNT);

  // memory, cleared by a sweep after reset
  logic [31:0]   mem [MEM_WORDS];
  logic [31:0]   mem_rdata;
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // input register
  logic        in_valid;
  logic        i_cmd;
  logic [31:0] i_ins;
  logic        i_irq2;
  logic [11:0] i_laddr;
  logic [31:0] i_ldata;

  // architectural state
  logic [31:0] rf [16];
  logic [31:0] io [IO_REG_COUNT];
  logic [31:0] io_next [IO_REG_COUNT];
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic [31:0] cycles;
  logic        busy;
  logic        busy_next;
  logic        halt;

  // pending load write back
  logic        wb_valid;
  logic [3:0]  wb_rd;

  logic        o_valid;
  logic [151:0] o_data;
  logic        fire;
  logic        exec;

  // decode
  logic [7:0]  op;
  logic [3:0]  rd;
  logic [3:0]  rs;
  logic [3:0]  rt;
  logic [31:0] imm;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] d;
  logic [31:0] idx;
  logic        idx_ok;
  logic [PC_W-1:0] pcn;
  alu_res_t    alu;

  logic        rf_we;
  logic [3:0]  rf_wa;
  logic [31:0] rf_wd;
  logic        ld_start;
  logic        st_we;
  logic        halt_set;
  logic        advance;
  logic [1:0]  acc;
  logic [4:0]  acc_idx;
  logic [31:0] acc_data;
  logic        leds_chg;
  logic        disp_chg;
  logic        irq_pend;

  function automatic logic [31:0] rd_reg(input logic [3:0] r, input logic [31:0] immv,
                                         input logic [31:0] rfv, input logic wbv,
                                         input logic [3:0] wbr, input logic [31:0] wbd);
    logic [31:0] v;
    if (r == 4'd0) v = '0;
    else if (r == 4'd1) v = immv;
    else if (wbv && wbr == r) v = wbd;
    else v = rfv;
    return v;
  endfunction

  assign fire     = in_valid && (i_cmd || !o_valid || m_tready);
  assign exec     = fire && !i_cmd;
  assign s_tready = !clearing && (!in_valid || fire);
  assign m_tvalid = o_valid;
  assign m_tdata  = o_data;

  assign op   = i_ins[31:24];
  assign rd   = i_ins[23:20];
  assign rs   = i_ins[19:16];
  assign rt   = i_ins[15:12];
  assign imm  = {{20{i_ins[11]}}, i_ins[11:0]};
  assign a    = rd_reg(rs, imm, rf[rs], wb_valid, wb_rd, mem_rdata);
  assign b    = rd_reg(rt, imm, rf[rt], wb_valid, wb_rd, mem_rdata);
  assign d    = rd_reg(rd, imm, rf[rd], wb_valid, wb_rd, mem_rdata);
  assign idx  = a + b;
  assign idx_ok = idx < 32'(IO_REG_COUNT);
  assign pcn  = pc + 1'b1;

  sp_alu u_alu (
    .op  (op),
    .a   (a),
    .b   (b),
    .res (alu)
  );

  always_comb begin
    io_next   = io;
    pc_next   = pc;
    busy_next = busy;
    rf_we     = 1'b0;
    rf_wa     = rd;
    rf_wd     = alu.value;
    ld_start  = 1'b0;
    st_we     = 1'b0;
    halt_set  = 1'b0;
    advance   = 1'b0;
    acc       = IO_NONE;
    acc_idx   = '0;
    acc_data  = '0;
    leds_chg  = 1'b0;
    disp_chg  = 1'b0;
    irq_pend  = 1'b0;
    if (!halt) begin
      if (op == OP_HALT) begin
        halt_set = 1'b1;
      end else begin
        advance = 1'b1;
        io_next[CLKS] = io[CLKS] + 1'b1;
        if (i_irq2) io_next[IRQ2_STATUS] = 32'd1;
        if (io[TIMER_ENABLE] != '0) begin
          if (io[TIMER_MAX] != '0 && io[TIMER_CUR] == io[TIMER_MAX]) begin
            io_next[TIMER_CUR]   = '0;
            io_next[IRQ0_STATUS] = 32'd1;
          end else begin
            io_next[TIMER_CUR] = io[TIMER_CUR] + 1'b1;
          end
        end
        if (io[IRQ0_ENABLE] != '0 && io_next[TIMER_CUR] == io[TIMER_MAX]) begin
          io_next[TIMER_CUR]   = '0;
          io_next[IRQ0_STATUS] = 32'd1;
        end
        case (op)
          OP_ADD, OP_SUB, OP_AND, OP_OR, OP_SLL, OP_SRA, OP_SRL: begin
            rf_we   = 1'b1;
            pc_next = pcn;
          end
          OP_BEQ, OP_BNE, OP_BLT, OP_BGT, OP_BLE, OP_BGE: begin
            pc_next = alu.taken ? d[PC_W-1:0] : pcn;
          end
          OP_JAL: begin
            rf_we   = 1'b1;
            rf_wa   = 4'd15;
            rf_wd   = 32'(pcn);
            pc_next = (rd == 4'd15) ? pcn : d[PC_W-1:0];
          end
          OP_LW: begin
            ld_start = 1'b1;
            pc_next  = pcn;
          end
          OP_SW: begin
            st_we   = 1'b1;
            pc_next = pcn;
          end
          OP_RETI: begin
            pc_next   = io[IRQ_RETURN][PC_W-1:0];
            busy_next = 1'b0;
          end
          OP_IN: begin
            rf_we   = 1'b1;
            rf_wd   = '0;
            pc_next = pcn;
            if (idx_ok) begin
              rf_wd    = io_next[idx[IOW-1:0]];
              acc      = IO_READ;
              acc_idx  = idx[4:0];
              acc_data = io_next[idx[IOW-1:0]];
            end
          end
          OP_OUT: begin
            pc_next = pcn;
            if (idx_ok) begin
              leds_chg = (idx == 32'(LEDS)) && (io_next[LEDS] != d);
              disp_chg = (idx == 32'(DISPLAY)) && (io_next[DISPLAY] != d);
              io_next[idx[IOW-1:0]] = d;
              acc      = IO_WRITE;
              acc_idx  = idx[4:0];
              acc_data = d;
            end
          end
          default: pc_next = pc;
        endcase
        irq_pend = (io_next[IRQ0_ENABLE] != '0 && io_next[IRQ0_STATUS] != '0) ||
                   (io_next[IRQ1_ENABLE] != '0 && io_next[IRQ1_STATUS] != '0) ||
                   (io_next[IRQ2_ENABLE] != '0 && io_next[IRQ2_STATUS] != '0);
        if (irq_pend && !busy_next) begin
          busy_next = 1'b1;
          io_next[IRQ_RETURN] = 32'(pc_next);
          pc_next = io_next[IRQ_HANDLER][PC_W-1:0];
        end
        io_next[IRQ2_STATUS] = '0;
      end
    end
  end

  // data memory: clear sweep, load command, store, registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (fire && i_cmd) begin
      mem[AW'(i_laddr)] <= i_ldata;
    end else if (exec && st_we) begin
      mem[idx[AW-1:0]] <= d;
    end
    if (exec && ld_start) begin
      mem_rdata <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(MEM_WORDS - 1)) clearing <= 1'b0;
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      i_cmd   <= s_tuser;
      i_ins   <= s_tdata[31:0];
      i_irq2  <= s_tdata[32];
      i_laddr <= s_tdata[44:33];
      i_ldata <= s_tdata[76:45];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      o_valid  <= 1'b0;
      wb_valid <= 1'b0;
      halt     <= 1'b0;
      busy     <= 1'b0;
      pc       <= '0;
      cycles   <= '0;
      for (int k = 0; k < 16; k++) rf[k] <= '0;
      for (int k = 0; k < IO_REG_COUNT; k++) io[k] <= '0;
    end else begin
      if (s_tvalid && s_tready) in_valid <= 1'b1;
      else if (fire) in_valid <= 1'b0;
      if (exec) o_valid <= 1'b1;
      else if (m_tready) o_valid <= 1'b0;
      // load data lands in the register file in the cycle after the read, unless
      // this cycle's write goes to the same register
      if (wb_valid && wb_rd > 4'd1 && !(exec && rf_we && rf_wa == wb_rd)) begin
        rf[wb_rd] <= mem_rdata;
      end
      wb_valid <= exec && ld_start;
      wb_rd    <= rd;
      if (exec) begin
        if (rf_we && rf_wa > 4'd1) rf[rf_wa] <= rf_wd;
        if (halt_set) halt <= 1'b1;
        if (advance) begin
          io     <= io_next;
          pc     <= pc_next;
          busy   <= busy_next;
          cycles <= cycles + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      o_data[11:0]    <= advance ? pc_next : pc;
      o_data[12]      <= !advance;
      o_data[44:13]   <= cycles;
      o_data[46:45]   <= acc;
      o_data[51:47]   <= acc_idx;
      o_data[83:52]   <= acc_data;
      o_data[84]      <= leds_chg;
      o_data[116:85]  <= advance ? io_next[LEDS] : io[LEDS];
      o_data[117]     <= disp_chg;
      o_data[149:118] <= advance ? io_next[DISPLAY] : io[DISPLAY];
      o_data[151:150] <= '0;
    end
  end

endmodule
`default_nettype wire

// File: sv/sp_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp_alu
// arithmetic, shift and branch compare unit
// ----------------------------------------------------------------------------
module sp_alu (
  input  wire logic [7:0]      op,
  input  wire logic [31:0]     a,
  input  wire logic [31:0]     b,
  output sp_pkg::alu_res_t     res
);
  import sp_pkg::*;

  logic [4:0] sh;
  logic       lt_ab;
  logic       lt_ba;

  assign sh    = b[4:0];
  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);

  always_comb begin
    res = '0;
    case (op)
      OP_ADD:  res.value = a + b;
      OP_SUB:  res.value = a - b;
      OP_AND:  res.value = a & b;
      OP_OR:   res.value = a | b;
      OP_SLL:  res.value = a << sh;
      OP_SRA:  res.value = $unsigned($signed(a) >>> sh);
      OP_SRL:  res.value = a >> sh;
      OP_BEQ:  res.taken = (a == b);
      OP_BNE:  res.taken = (a != b);
      OP_BLT:  res.taken = lt_ab;
      OP_BGT:  res.taken = lt_ba;
      OP_BLE:  res.taken = !lt_ba;
      OP_BGE:  res.taken = !lt_ab;
      default: res = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/sp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp_checker
// port level checks of the risc core
// ----------------------------------------------------------------------------
module sp_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [151:0] m_tdata
);
  import sp_pkg::*;

  // no beat can enter or leave right after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !m_tvalid && !s_tready)
    else $error("activity right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped");

  a_noaccess: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[46:45] == IO_NONE |-> m_tdata[51:47] == '0 &&
    m_tdata[83:52] == '0 && !m_tdata[84] && !m_tdata[117])
    else $error("i/o fields set without access");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[12] |-> m_tdata[46:45] == IO_NONE)
    else $error("access reported while halted");

endmodule

bind simple_risc_core_with_interrupts sp_checker u_sp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// File: test/tb_simple_risc_core_with_interrupts.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simple_risc_core_with_interrupts
// drives instruction and memory-load beats into the core, predicts every
// result beat with a behavioral copy of the machine and compares field by field
// ----------------------------------------------------------------------------
module tb_simple_risc_core_with_interrupts;
  import sp_pkg::*;

  localparam int MEM_WORDS = 4096;
  localparam int IO_REGS   = 18;
  localparam int LIMIT     = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [151:0] m_tdata;

  simple_risc_core_with_interrupts u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  typedef struct packed {
    logic [31:0] disp_val;
    logic        disp_chg;
    logic [31:0] leds_val;
    logic        leds_chg;
    logic [31:0] io_dat;
    logic [4:0]  io_idx;
    logic [1:0]  io_acc;
    logic [31:0] cyc;
    logic        halted;
    logic [11:0] pc;
  } core_result_t;

  // machine state mirror
  logic [31:0] regs [16];
  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] ioreg [IO_REGS];
  logic [11:0] pc_q;
  logic [31:0] cyc_q;
  logic        busy_q, halt_q;

  core_result_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial forever #5 clk = ~clk;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, exp);
  endtask

  function automatic core_result_t idle_result();
    core_result_t r;
    r = '0;
    r.pc = pc_q; r.halted = halt_q; r.cyc = cyc_q;
    r.leds_val = ioreg[LEDS]; r.disp_val = ioreg[DISPLAY];
    return r;
  endfunction

  function automatic logic slt(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // returns 1 when the beat makes a result
  function automatic bit execute_beat(input logic cmd, input logic [31:0] ins, input logic irq2,
                                      input logic [11:0] ladr, input logic [31:0] ldat,
                                      output core_result_t r);
    logic [7:0] op;
    logic [3:0] rd, rs, rt;
    logic [31:0] a, b, d, idx;
    logic [11:0] pc, pcn;
    logic [4:0] sh;
    if (cmd) begin
      dmem[ladr] = ldat;
      return 0;
    end
    if (halt_q) begin
      r = idle_result();
      return 1;
    end
    op = ins[31:24]; rd = ins[23:20]; rs = ins[19:16]; rt = ins[15:12];
    regs[1] = {{20{ins[11]}}, ins[11:0]};
    if (op == OP_HALT) begin
      halt_q = 1'b1;
      r = idle_result();
      return 1;
    end
    r = '0;
    ioreg[CLKS]++;
    if (irq2) ioreg[IRQ2_STATUS] = 32'd1;
    if (ioreg[TIMER_ENABLE] != 0) begin
      if (ioreg[TIMER_MAX] != 0 && ioreg[TIMER_CUR] == ioreg[TIMER_MAX]) begin
        ioreg[TIMER_CUR] = 0; ioreg[IRQ0_STATUS] = 32'd1;
      end else ioreg[TIMER_CUR]++;
    end
    if (ioreg[IRQ0_ENABLE] != 0 && ioreg[TIMER_CUR] == ioreg[TIMER_MAX]) begin
      ioreg[TIMER_CUR] = 0; ioreg[IRQ0_STATUS] = 32'd1;
    end
    a = regs[rs]; b = regs[rt]; d = regs[rd];
    pc = pc_q; pcn = pc_q + 12'd1; sh = b[4:0]; idx = a + b;
    case (op)
      OP_ADD: begin if (rd != 0) regs[rd] = a + b; pc = pcn; end
      OP_SUB: begin if (rd != 0) regs[rd] = a - b; pc = pcn; end
      OP_AND: begin if (rd != 0) regs[rd] = a & b; pc = pcn; end
      OP_OR:  begin if (rd != 0) regs[rd] = a | b; pc = pcn; end
      OP_SLL: begin if (rd != 0) regs[rd] = a << sh; pc = pcn; end
      OP_SRA: begin if (rd != 0) regs[rd] = $signed(a) >>> sh; pc = pcn; end
      OP_SRL: begin if (rd != 0) regs[rd] = a >> sh; pc = pcn; end
      OP_BEQ: pc = (a == b) ? d[11:0] : pcn;
      OP_BNE: pc = (a != b) ? d[11:0] : pcn;
      OP_BLT: pc = slt(a, b) ? d[11:0] : pcn;
      OP_BGT: pc = slt(b, a) ? d[11:0] : pcn;
      OP_BLE: pc = !slt(b, a) ? d[11:0] : pcn;
      OP_BGE: pc = !slt(a, b) ? d[11:0] : pcn;
      OP_JAL: begin regs[15] = {20'd0, pcn}; pc = regs[rd][11:0]; end
      OP_LW:  begin if (rd != 0) regs[rd] = dmem[idx[11:0]]; pc = pcn; end
      OP_SW:  begin dmem[idx[11:0]] = d; pc = pcn; end
      OP_RETI: begin pc = ioreg[IRQ_RETURN][11:0]; busy_q = 1'b0; end
      OP_IN: begin
        if (idx < IO_REGS) begin
          if (rd != 0) regs[rd] = ioreg[idx];
          r.io_acc = IO_READ; r.io_idx = idx[4:0]; r.io_dat = ioreg[idx];
        end else if (rd != 0) regs[rd] = 0;
        pc = pcn;
      end
      OP_OUT: begin
        if (idx < IO_REGS) begin
          if (idx == LEDS && ioreg[LEDS] != d) r.leds_chg = 1'b1;
          if (idx == DISPLAY && ioreg[DISPLAY] != d) r.disp_chg = 1'b1;
          ioreg[idx] = d;
          r.io_acc = IO_WRITE; r.io_idx = idx[4:0]; r.io_dat = d;
        end
        pc = pcn;
      end
      default: ;
    endcase
    if (((ioreg[IRQ0_ENABLE] != 0 && ioreg[IRQ0_STATUS] != 0) ||
         (ioreg[IRQ1_ENABLE] != 0 && ioreg[IRQ1_STATUS] != 0) ||
         (ioreg[IRQ2_ENABLE] != 0 && ioreg[IRQ2_STATUS] != 0)) && !busy_q) begin
      busy_q = 1'b1;
      ioreg[IRQ_RETURN] = {20'd0, pc};
      pc = ioreg[IRQ_HANDLER][11:0];
    end
    ioreg[IRQ2_STATUS] = 0;
    pc_q = pc;
    r.pc = pc; r.cyc = cyc_q;
    r.leds_val = ioreg[LEDS]; r.disp_val = ioreg[DISPLAY];
    cyc_q++;
    return 1;
  endfunction

  // valid stays up after the beat so back to back beats need one assignment
  task automatic send_beat(input logic cmd, input logic [31:0] ins, input logic irq2,
                           input logic [11:0] ladr, input logic [31:0] ldat);
    core_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, ldat, ladr, irq2, ins};
    do @(posedge clk); while (!s_tready);
    if (execute_beat(cmd, ins, irq2, ladr, ldat, r)) expected_q.push_back(r);
  endtask

  function automatic logic [31:0] mk_ins(input opcode_t op, input int rd, input int rs,
                                         input int rt, input int imm);
    return {op, rd[3:0], rs[3:0], rt[3:0], imm[11:0]};
  endfunction

  // loads r1 immediate into rd with add rd, r0, r1
  task automatic li(input int rd, input int imm);
    send_beat(1'b0, mk_ins(OP_ADD, rd, 0, 1, imm), 1'b0, '0, '0);
  endtask

  task automatic out_io(input int idx, input int val);
    li(2, val);
    send_beat(1'b0, mk_ins(OP_OUT, 2, 0, 1, idx), 1'b0, '0, '0);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    core_result_t g, e;
    if (!rst) begin
      cycles++;
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        g = m_tdata[149:0];
        if (expected_q.size() == 0) begin
          errors++;
          $display("unexpected result beat");
        end else begin
          e = expected_q.pop_front();
          if (g.pc !== e.pc) report("next_pc", g.pc, e.pc);
          if (g.halted !== e.halted) report("halted", g.halted, e.halted);
          if (g.cyc !== e.cyc) report("cycle_number", g.cyc, e.cyc);
          if (g.io_acc !== e.io_acc) report("io_access", g.io_acc, e.io_acc);
          if (g.io_idx !== e.io_idx) report("io_index", g.io_idx, e.io_idx);
          if (g.io_dat !== e.io_dat) report("io_data", g.io_dat, e.io_dat);
          if (g.leds_chg !== e.leds_chg) report("leds_changed", g.leds_chg, e.leds_chg);
          if (g.leds_val !== e.leds_val) report("leds_value", g.leds_val, e.leds_val);
          if (g.disp_chg !== e.disp_chg) report("display_changed", g.disp_chg, e.disp_chg);
          if (g.disp_val !== e.disp_val) report("display_value", g.disp_val, e.disp_val);
        end
      end
      if (cycles > LIMIT) begin
        $display("simple_risc_core_with_interrupts verification failed");
        $finish;
      end
    end
  end

  task automatic test_directed();
    int op;
    for (op = 0; op <= 18; op++) begin
      send_beat(1'b0, {op[7:0], 4'd3, 4'd1, 4'd1, 12'h800}, 1'b0, '0, '0);
    end
    li(4, 12'h7ff);
    li(5, 12'h800);
    send_beat(1'b0, mk_ins(OP_SRL, 6, 5, 1, 12'h01f), 1'b0, '0, '0);
    send_beat(1'b0, mk_ins(OP_ADD, 0, 4, 4, 0), 1'b0, '0, '0);
    send_beat(1'b1, '0, 1'b0, 12'hfff, 32'hffffffff);
    send_beat(1'b0, mk_ins(OP_LW, 7, 0, 1, 12'hfff), 1'b0, '0, '0);
    send_beat(1'b0, mk_ins(OP_IN, 8, 0, 1, 12'd40), 1'b0, '0, '0);
    send_beat(1'b0, 32'hffffffff, 1'b1, '0, '0);
    send_beat(1'b0, mk_ins(OP_JAL, 15, 0, 1, 0), 1'b0, '0, '0);
  endtask

  // sets up timer, irq handler and irq enables, then random programs
  task automatic test_random(input int n);
    int i, pick, opi;
    logic [31:0] ins;
    out_io(IRQ_HANDLER, $urandom_range(4095));
    out_io(TIMER_MAX, $urandom_range(40));
    out_io(TIMER_ENABLE, 1);
    out_io(IRQ0_ENABLE, $urandom_range(1));
    out_io(IRQ2_ENABLE, 1);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      ins = $urandom;
      if (pick < 3) begin
        send_beat(1'b1, '0, 1'b0, 12'($urandom_range(4095)), $urandom);
        continue;
      end
      if (pick < 88) opi = $urandom_range(18);
      else if (pick < 96) opi = OP_RETI;
      else opi = $urandom_range(255);
      if (opi == OP_HALT) opi = OP_ADD;
      ins[31:24] = opi[7:0];
      // keep i/o indexes small so most in/out hit a register
      if ((opi == OP_IN || opi == OP_OUT) && pick < 70) begin
        ins[19:16] = 4'd0; ins[15:12] = 4'd1; ins[11:0] = 12'($urandom_range(19));
      end
      send_beat(1'b0, ins, ($urandom_range(15) == 0), 12'($urandom), $urandom);
    end
  endtask

  task automatic test_halt();
    send_beat(1'b0, mk_ins(OP_HALT, 0, 0, 0, 0), 1'b0, '0, '0);
    repeat (6) send_beat(1'b0, $urandom, 1'b1, '0, '0);
    send_beat(1'b1, '0, 1'b0, 12'd5, $urandom);
    send_beat(1'b0, $urandom, 1'b0, '0, '0);
  endtask

  initial begin : main
    int k;
    for (k = 0; k < 16; k++) regs[k] = 0;
    for (k = 0; k < MEM_WORDS; k++) dmem[k] = 0;
    for (k = 0; k < IO_REGS; k++) ioreg[k] = 0;
    pc_q = 0; cyc_q = 0; busy_q = 0; halt_q = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(500);
    drain();
    send_idle_pct = 65;
    test_random(500);
    send_idle_pct = 0; recv_stall_pct = 65;
    test_random(500);
    send_idle_pct = 13; recv_stall_pct = 13;
    test_random(500);
    recv_stall_pct = 0; send_idle_pct = 0;
    test_halt();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("simple_risc_core_with_interrupts verification clean");
    end else begin
      $display("simple_risc_core_with_interrupts verification failed");
    end
    $finish;
  end
endmodule
